@@ src/edsp_pkg.sv @@
// Package for the error diffusion seed picker: field widths, configuration
// register indexes and reset values, and the seed record type.
// Depends on nothing; every other file of the block but edsp_ram uses it.
package edsp_pkg;

    localparam int DENSITY_BITS = 20;
    localparam int RADIUS_BITS  = 16;
    localparam int COORD_BITS   = 10;
    localparam int DIM_BITS     = 11;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = DIM_BITS;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [DIM_BITS-1:0] HEIGHT_MIN       = 11'd2;
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX       = 11'd1024;

    typedef struct packed {
        logic [COORD_BITS-1:0]  seed_x;
        logic [COORD_BITS-1:0]  seed_y;
        logic [RADIUS_BITS-1:0] seed_radius;
    } t_seed;

endpackage

@@ src/edsp_pix_if.sv @@
// Pixel input channel of the seed picker: valid/ready handshake with
// density and radius payload. Depends on edsp_pkg.
interface edsp_pix_if;
    logic                               valid;
    logic                               ready;
    logic [edsp_pkg::DENSITY_BITS-1:0]  density;
    logic [edsp_pkg::RADIUS_BITS-1:0]   pixel_radius;

    modport source (output valid, output density, output pixel_radius, input ready);
    modport sink   (input valid, input density, input pixel_radius, output ready);
endinterface

@@ src/edsp_seed_if.sv @@
// Seed output channel of the seed picker: valid/ready handshake with
// seed coordinates and radius payload. Depends on edsp_pkg.
interface edsp_seed_if;
    logic                               valid;
    logic                               ready;
    logic [edsp_pkg::COORD_BITS-1:0]    seed_x;
    logic [edsp_pkg::COORD_BITS-1:0]    seed_y;
    logic [edsp_pkg::RADIUS_BITS-1:0]   seed_radius;

    modport source (output valid, output seed_x, output seed_y, output seed_radius,
                    input ready);
    modport sink   (input valid, input seed_x, input seed_y, input seed_radius,
                    output ready);
endinterface

@@ src/edsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No dependencies.
module edsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/error_diffusion_seed_picker.sv @@
// Floyd-Steinberg error diffusion seed picker: top level. Uses edsp_pkg,
// edsp_pix_if, edsp_seed_if and edsp_ram (the error line buffer).
// Throughput: one pixel item per cycle while the output queue has room, bounded
// by the line-buffer read and write per pixel and the right-error feedback loop.
// A seed item is written to the output queue from stage 1 and offered from there.
// Reset (synchronous, active low) clears counters and errors; the line buffer is not cleared.
module error_diffusion_seed_picker #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [edsp_pkg::CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [edsp_pkg::CFG_DATA_BITS-1:0] i_cfg_wr_data,
    edsp_pix_if.sink                           i_pix,
    edsp_seed_if.source                        o_seed
);

    // ------------------------------------------------------------------
    // Widths and constants. Every accumulator is a signed Q7.FRAC value.
    // The raw three-term sum is kept wide enough that it never wraps
    // before saturation.
    // ------------------------------------------------------------------
    localparam int ACC_BITS = FRAC_BITS + 8;
    localparam int SUM_BITS = ((ACC_BITS > edsp_pkg::DENSITY_BITS + 1) ?
                               ACC_BITS : edsp_pkg::DENSITY_BITS + 1) + 2;
    localparam int PROD_BITS = ACC_BITS + 3;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WCMP_BITS = (COL_BITS + 1 > edsp_pkg::DIM_BITS) ?
                               COL_BITS + 1 : edsp_pkg::DIM_BITS;

    localparam logic signed [SUM_BITS-1:0] SAT_MAX =
        {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_MIN =
        {{(SUM_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] ONE  = ACC_BITS'(1) << FRAC_BITS;
    localparam logic [WCMP_BITS-1:0] WIDTH_MIN = WCMP_BITS'(3);
    localparam logic [WCMP_BITS-1:0] WIDTH_MAX = WCMP_BITS'(MAX_WIDTH);

    function automatic logic signed [ACC_BITS-1:0] f_sat(input logic signed [SUM_BITS-1:0] a);
        logic signed [ACC_BITS-1:0] res;
        if (a > SAT_MAX) begin
            res = SAT_MAX[ACC_BITS-1:0];
        end else if (a < SAT_MIN) begin
            res = SAT_MIN[ACC_BITS-1:0];
        end else begin
            res = a[ACC_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SUM_BITS-1:0] f_ext(input logic signed [ACC_BITS-1:0] a);
        return {{(SUM_BITS-ACC_BITS){a[ACC_BITS-1]}}, a};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, to be written by the user only while the block is idle
    // (the block does not enforce it), so the frame geometry below may be decoded combinationally.
    // ------------------------------------------------------------------
    logic [edsp_pkg::DIM_BITS-1:0] r_frame_width;
    logic [edsp_pkg::DIM_BITS-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= edsp_pkg::FRAME_WIDTH_RST;
            r_frame_height <= edsp_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                edsp_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wr_data;
                edsp_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wr_data;
            endcase
        end
    end

    // Out-of-range geometry is clamped: width to 3..MAX_WIDTH, height to
    // 2..1024.
    logic [WCMP_BITS-1:0]          eff_width;
    logic [edsp_pkg::DIM_BITS-1:0] eff_height;

    always_comb begin
        eff_width = WCMP_BITS'(r_frame_width);
        if (eff_width < WIDTH_MIN) begin
            eff_width = WIDTH_MIN;
        end else if (eff_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end
        eff_height = r_frame_height;
        if (eff_height < edsp_pkg::HEIGHT_MIN) begin
            eff_height = edsp_pkg::HEIGHT_MIN;
        end else if (eff_height > edsp_pkg::HEIGHT_MAX) begin
            eff_height = edsp_pkg::HEIGHT_MAX;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: raster position counters. The column counter addresses the
    // line buffer directly, so the below-error of the accepted pixel comes
    // out of the RAM in the following cycle, aligned with stage 1.
    // A column at or past the last column is treated as the last one, and
    // the same holds for rows; this makes a mid-frame geometry change wrap.
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0]             r_col;
    logic [edsp_pkg::COORD_BITS-1:0] r_row;
    logic                            in_accept;
    logic                            last_col;
    logic                            last_row;

    assign in_accept = i_pix.valid && i_pix.ready;
    assign last_col  = WCMP_BITS'(r_col) >= (eff_width - WCMP_BITS'(1));
    assign last_row  = {1'b0, r_row} >= (eff_height - edsp_pkg::DIM_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Stage 1 pipeline register: the pixel's payload and its position flags.
    logic                               r_s1_vld;
    logic [COL_BITS-1:0]                r_s1_x;
    logic [edsp_pkg::COORD_BITS-1:0]    r_s1_y;
    logic                               r_s1_first;
    logic                               r_s1_last_col;
    logic                               r_s1_last_row;
    logic                               r_s1_row0;
    logic [edsp_pkg::DENSITY_BITS-1:0]  r_s1_density;
    logic [edsp_pkg::RADIUS_BITS-1:0]   r_s1_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_accept;
        end
        if (in_accept) begin
            r_s1_x        <= r_col;
            r_s1_y        <= r_row;
            r_s1_first    <= (r_col == '0);
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
            r_s1_row0     <= (r_row == '0);
            r_s1_density  <= i_pix.density;
            r_s1_radius   <= i_pix.pixel_radius;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer of below-row errors. Pixel x writes entry x-1 in stage 1;
    // the last column also writes entry x, which is deferred to the following cycle
    // into a slot that is always free because the next pixel is column 0,
    // which never writes. A later read of either entry is at least two
    // items behind the write (width is at least 3), so a read never meets
    // a write to the same entry in the same cycle and no forwarding is
    // needed.
    // ------------------------------------------------------------------
    logic                      s1_wr_en;
    logic [COL_BITS-1:0]       s1_wr_addr;
    logic signed [ACC_BITS-1:0] s1_wr_data;
    logic                      r_defer_vld;
    logic [COL_BITS-1:0]       r_defer_addr;
    logic [ACC_BITS-1:0]       r_defer_data;
    logic                      ram_wr_en;
    logic [COL_BITS-1:0]       ram_wr_addr;
    logic [ACC_BITS-1:0]       ram_wr_data;
    logic [ACC_BITS-1:0]       ram_rd_data;

    assign ram_wr_en   = s1_wr_en || r_defer_vld;
    assign ram_wr_addr = r_defer_vld ? r_defer_addr : s1_wr_addr;
    assign ram_wr_data = r_defer_vld ? r_defer_data : s1_wr_data;

    edsp_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: diffusion. The pixel value is density plus the error from
    // below plus either the right error (interior and last column) or the
    // row carry (column 0). Row 0 sees neither below error nor row carry.
    // ------------------------------------------------------------------
    logic signed [ACC_BITS-1:0]  r_right_err;
    logic signed [ACC_BITS-1:0]  r_pend0;
    logic signed [ACC_BITS-1:0]  r_pend1;
    logic signed [ACC_BITS-1:0]  r_row_carry;
    logic signed [ACC_BITS-1:0]  n_right_err;
    logic signed [ACC_BITS-1:0]  n_pend0;
    logic signed [ACC_BITS-1:0]  n_pend1;
    logic signed [ACC_BITS-1:0]  n_row_carry;
    logic                        n_defer_vld;

    logic signed [ACC_BITS-1:0]  below_err;
    logic signed [ACC_BITS-1:0]  side_err;
    logic signed [SUM_BITS-1:0]  raw_sum;
    logic signed [ACC_BITS-1:0]  pix_val;
    logic                        hit;
    logic signed [ACC_BITS-1:0]  resid;
    logic signed [PROD_BITS-1:0] resid_x;
    logic signed [PROD_BITS-1:0] prod7;
    logic signed [PROD_BITS-1:0] prod3;
    logic signed [PROD_BITS-1:0] prod5;
    logic signed [PROD_BITS-1:0] shr7;
    logic signed [PROD_BITS-1:0] shr3;
    logic signed [PROD_BITS-1:0] shr5;
    logic signed [PROD_BITS-1:0] shr1;
    logic signed [ACC_BITS-1:0]  w7;
    logic signed [ACC_BITS-1:0]  w3;
    logic signed [ACC_BITS-1:0]  w5;
    logic signed [ACC_BITS-1:0]  w1;

    assign below_err = r_s1_row0 ? '0 : $signed(ram_rd_data);
    assign side_err  = !r_s1_first ? r_right_err : (r_s1_row0 ? '0 : r_row_carry);
    assign raw_sum   = $signed({{(SUM_BITS-edsp_pkg::DENSITY_BITS){1'b0}}, r_s1_density})
                     + f_ext(below_err) + f_ext(side_err);
    assign pix_val   = f_sat(raw_sum);

    // Threshold at one half; a hit takes one seed's worth out of the value.
    // The result never leaves the accumulator range since it is at least
    // one half minus one.
    assign hit   = r_s1_vld && !r_s1_last_row && !r_s1_first && !r_s1_last_col
                && (pix_val >= HALF);
    assign resid = hit ? pix_val - ONE : pix_val;

    // Weights k/16 as shift-and-add products followed by an arithmetic
    // shift, which floors toward minus infinity.
    assign resid_x = {{(PROD_BITS-ACC_BITS){resid[ACC_BITS-1]}}, resid};
    assign prod7   = (resid_x <<< 3) - resid_x;
    assign prod3   = (resid_x <<< 1) + resid_x;
    assign prod5   = (resid_x <<< 2) + resid_x;
    assign shr7    = prod7 >>> 4;
    assign shr3    = prod3 >>> 4;
    assign shr5    = prod5 >>> 4;
    assign shr1    = resid_x >>> 4;
    assign w7      = shr7[ACC_BITS-1:0];
    assign w3      = shr3[ACC_BITS-1:0];
    assign w5      = shr5[ACC_BITS-1:0];
    assign w1      = shr1[ACC_BITS-1:0];

    always_comb begin
        n_right_err = r_right_err;
        n_pend0     = r_pend0;
        n_pend1     = r_pend1;
        n_row_carry = r_row_carry;
        n_defer_vld = 1'b0;
        s1_wr_en    = 1'b0;
        s1_wr_addr  = r_s1_x - 1'b1;
        s1_wr_data  = r_pend0;
        // The last row only advances the counters.
        if (r_s1_vld && !r_s1_last_row) begin
            if (r_s1_first) begin
                // Column 0 hands its whole value to column 1.
                n_right_err = pix_val;
                n_pend0     = '0;
                n_pend1     = '0;
            end else if (r_s1_last_col) begin
                // The last column carries into column 0 of the next row and
                // flushes both pending below-errors.
                n_row_carry = pix_val;
                s1_wr_en    = 1'b1;
                n_defer_vld = 1'b1;
            end else begin
                n_right_err = w7;
                s1_wr_en    = 1'b1;
                s1_wr_data  = f_sat(f_ext(r_pend0) + f_ext(w3));
                n_pend0     = f_sat(f_ext(r_pend1) + f_ext(w5));
                n_pend1     = w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_err <= '0;
            r_pend0     <= '0;
            r_pend1     <= '0;
            r_row_carry <= '0;
            r_defer_vld <= 1'b0;
        end else begin
            r_right_err <= n_right_err;
            r_pend0     <= n_pend0;
            r_pend1     <= n_pend1;
            r_row_carry <= n_row_carry;
            r_defer_vld <= n_defer_vld;
        end
        r_defer_addr <= r_s1_x;
        r_defer_data <= r_pend1;
    end

    // ------------------------------------------------------------------
    // Two-entry output queue. Stage 1 never stalls, so an item is accepted
    // only when the queue is sure to have room for the seed it may produce
    // in stage 1: the occupancy after this cycle, counting the item in stage 1
    // as if it hits, must stay at most one. With a ready sink this keeps
    // one item per cycle flowing.
    // ------------------------------------------------------------------
    edsp_pkg::t_seed r_fifo [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            deq;
    logic [2:0]      occ_next;

    assign deq      = o_seed.valid && o_seed.ready;
    assign occ_next = 3'(r_count) + 3'(r_s1_vld) - 3'(deq);
    assign i_pix.ready = occ_next < 3'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (hit) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (deq) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= 2'(3'(r_count) + 3'(hit) - 3'(deq));
        end
        if (hit) begin
            r_fifo[r_wr_ptr] <= '{seed_x:      edsp_pkg::COORD_BITS'(r_s1_x),
                                  seed_y:      r_s1_y,
                                  seed_radius: r_s1_radius};
        end
    end

    assign o_seed.valid       = (r_count != '0);
    assign o_seed.seed_x      = r_fifo[r_rd_ptr].seed_x;
    assign o_seed.seed_y      = r_fifo[r_rd_ptr].seed_y;
    assign o_seed.seed_radius = r_fifo[r_rd_ptr].seed_radius;

`ifndef ASSERT_OFF
    // The deferred last-column write must never collide with a stage 1 write.
    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_wr_en && r_defer_vld))
        else $error("line buffer: two writes in one cycle");

    // A full queue means no item can be in stage 1.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !r_s1_vld)
        else $error("output queue full while stage 1 busy");

    // After an accepted last-column pixel the raster restarts at column 0.
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && last_col) |=> (r_col == '0))
        else $error("column counter did not wrap");
`endif

endmodule

@@ verif/edsp_seed_checker.sv @@
// Seed scoreboard for the error diffusion seed picker: it follows the register
// writes and the pixel items, predicts each seed and checks the seed channel.
// Depends on edsp_pkg.
module edsp_seed_checker #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [edsp_pkg::CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [edsp_pkg::CFG_DATA_BITS-1:0] i_cfg_wr_data,
    input  logic                               i_pix_valid,
    input  logic                               i_pix_ready,
    input  logic [edsp_pkg::DENSITY_BITS-1:0]  i_density,
    input  logic [edsp_pkg::RADIUS_BITS-1:0]   i_pixel_radius,
    input  logic                               i_seed_valid,
    input  logic                               i_seed_ready,
    input  logic [edsp_pkg::COORD_BITS-1:0]    i_seed_x,
    input  logic [edsp_pkg::COORD_BITS-1:0]    i_seed_y,
    input  logic [edsp_pkg::RADIUS_BITS-1:0]   i_seed_radius,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_seeds_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ACC_BITS  = FRAC_BITS + 8;
    localparam longint ACC_MAX   = (64'sd1 << (ACC_BITS - 1)) - 64'sd1;
    localparam longint ACC_MIN   = -ACC_MAX - 64'sd1;
    localparam longint HALF      = 64'sd1 << (FRAC_BITS - 1);
    localparam longint ONE       = 64'sd1 << FRAC_BITS;
    localparam int     WIDTH_MIN = 3;
    localparam int     REPORT_MAX = 10;

    typedef logic signed [ACC_BITS-1:0] t_acc;

    // Predictor state, Q7.FRAC_BITS accumulators.
    t_acc                          err_line [MAX_WIDTH];
    t_acc                          right_err;
    t_acc                          pend_lo;
    t_acc                          pend_hi;
    t_acc                          row_carry;
    int                            col_cnt;
    int                            row_cnt;
    logic [edsp_pkg::DIM_BITS-1:0] width_reg;
    logic [edsp_pkg::DIM_BITS-1:0] height_reg;

    edsp_pkg::t_seed     seed_q [$];
    int                  fails;
    int                  checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    function automatic int clamp_dim(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_acc(longint a);
        if (a > ACC_MAX) return ACC_MAX;
        if (a < ACC_MIN) return ACC_MIN;
        return a;
    endfunction

    // k/16 of a, floored by the arithmetic shift.
    function automatic longint weigh16(longint a, int k);
        return (a * k) >>> 4;
    endfunction

    task automatic diffuse_pixel(input logic [edsp_pkg::DENSITY_BITS-1:0] dens,
                                 input logic [edsp_pkg::RADIUS_BITS-1:0] rad);
        int              w;
        int              h;
        int              x;
        int              y;
        bit              last_col;
        bit              last_row;
        longint          dv;
        longint          below;
        longint          carry;
        longint          v;
        edsp_pkg::t_seed s;
        w        = clamp_dim(int'(width_reg), WIDTH_MIN, MAX_WIDTH);
        h        = clamp_dim(int'(height_reg), int'(edsp_pkg::HEIGHT_MIN),
                             int'(edsp_pkg::HEIGHT_MAX));
        x        = col_cnt;
        y        = row_cnt;
        last_col = (x >= w - 1);
        last_row = (y >= h - 1);
        dv       = longint'(dens);
        if (!last_row) begin
            below = 0;
            if (y != 0 && x < MAX_WIDTH) below = err_line[x];
            if (x == 0) begin
                carry     = (y != 0) ? longint'(row_carry) : 64'sd0;
                right_err = t_acc'(sat_acc(dv + below + carry));
                pend_lo   = '0;
                pend_hi   = '0;
            end else if (last_col) begin
                row_carry       = t_acc'(sat_acc(dv + below + right_err));
                err_line[x - 1] = pend_lo;
                err_line[x]     = pend_hi;
            end else begin
                v = sat_acc(dv + below + right_err);
                if (v >= HALF) begin
                    v             = v - ONE;
                    s.seed_x      = edsp_pkg::COORD_BITS'(x);
                    s.seed_y      = edsp_pkg::COORD_BITS'(y);
                    s.seed_radius = rad;
                    seed_q        = {seed_q, s};
                end
                right_err       = t_acc'(sat_acc(weigh16(v, 7)));
                err_line[x - 1] = t_acc'(sat_acc(pend_lo + weigh16(v, 3)));
                pend_lo         = t_acc'(sat_acc(pend_hi + weigh16(v, 5)));
                pend_hi         = t_acc'(sat_acc(weigh16(v, 1)));
            end
        end
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
        end
    endtask

    always @(posedge i_clk) begin : observe
        edsp_pkg::t_seed got;
        edsp_pkg::t_seed want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) err_line[i] = '0;
            right_err  = '0;
            pend_lo    = '0;
            pend_hi    = '0;
            row_carry  = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = edsp_pkg::FRAME_WIDTH_RST;
            height_reg = edsp_pkg::FRAME_HEIGHT_RST;
            seed_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == edsp_pkg::CFG_FRAME_WIDTH) width_reg = i_cfg_wr_data;
                else if (i_cfg_addr == edsp_pkg::CFG_FRAME_HEIGHT) height_reg = i_cfg_wr_data;
            end
            if (i_pix_valid && i_pix_ready) diffuse_pixel(i_density, i_pixel_radius);
            if (i_seed_valid && i_seed_ready) begin
                got.seed_x      = i_seed_x;
                got.seed_y      = i_seed_y;
                got.seed_radius = i_seed_radius;
                if (seed_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: seed x=%0d y=%0d r=%h arrived with none predicted",
                                 $realtime, got.seed_x, got.seed_y, got.seed_radius);
                end else begin
                    want = seed_q.pop_front();
                    checked++;
                    if (want.seed_x !== got.seed_x || want.seed_y !== got.seed_y ||
                        want.seed_radius !== got.seed_radius) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: seed expected x=%0d y=%0d r=%h, got x=%0d y=%0d r=%h",
                                     $realtime, want.seed_x, want.seed_y, want.seed_radius,
                                     got.seed_x, got.seed_y, got.seed_radius);
                    end
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= seed_q.size();
        o_seeds_checked <= checked;
    end

endmodule

@@ verif/tb_error_diffusion_seed_picker.sv @@
// Top of the seed picker testbench: clock, reset, pixel stimulus, seed sink
// with random back-pressure, and the verdict. Depends on edsp_pkg, the two
// channel interfaces, the block itself and edsp_seed_checker.
module tb_error_diffusion_seed_picker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      MAX_W          = 1024;
    localparam int      FRAC_B         = 16;
    localparam int      WIDTH_MIN      = 3;
    localparam int      DIRECTED_ITEMS = 24;
    localparam int      RANDOM_ITEMS   = 1926;
    localparam int      MAX_GAP        = 15;
    // One long stall of the seed side, long enough to fill whatever buffering
    // the block has and push back on the pixel side.
    localparam int      LONG_HOLD      = 400;
    localparam int      PRESSURE_PHASE = 3;
    // The longest correct stretch with no item moving is the long hold above;
    // ordinary gaps and stalls are bounded by MAX_GAP, and the watchdog limit
    // is set above the long hold.
    localparam int      IDLE_LIMIT     = 4000;
    localparam int      SETTLE_CYCLES  = 4;
    localparam int      END_CYCLES     = 10;
    localparam realtime HALF_PERIOD    = 1.0;

    typedef enum int {
        DENS_FULL,
        DENS_HALF,
        DENS_SPARSE,
        DENS_HEAVY,
        DENS_MIXED
    } t_dens_mode;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               cfg_wr_en   = 1'b0;
    edsp_pkg::t_cfg_idx                 cfg_addr    = edsp_pkg::CFG_FRAME_WIDTH;
    logic [edsp_pkg::CFG_DATA_BITS-1:0] cfg_wr_data = '0;

    edsp_pix_if  pix ();
    edsp_seed_if seed ();

    int fail_count;
    int pending_seeds;
    int seeds_checked;

    // Stimulus-side view of the frame position. It is kept only so that a
    // width change never makes a later row read a line-buffer entry that no
    // row has written yet (the buffer is not cleared by reset).
    logic [edsp_pkg::DIM_BITS-1:0] shadow_w   = edsp_pkg::FRAME_WIDTH_RST;
    logic [edsp_pkg::DIM_BITS-1:0] shadow_h   = edsp_pkg::FRAME_HEIGHT_RST;
    int                            pos_col    = 0;
    int                            pos_row    = 0;
    int                            buf_extent = 0;

    int pixels_sent    = 0;
    int frame_settings = 0;

    // Per-phase idling switches, set by the stimulus and read by the sink.
    bit tx_no_gap    = 1'b0;
    bit rx_no_stall  = 1'b0;
    bit rx_long_hold = 1'b0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    error_diffusion_seed_picker #(
        .MAX_WIDTH (MAX_W),
        .FRAC_BITS (FRAC_B)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .i_pix         (pix),
        .o_seed        (seed)
    );

    edsp_seed_checker #(
        .MAX_WIDTH (MAX_W),
        .FRAC_BITS (FRAC_B)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_pix_valid     (pix.valid),
        .i_pix_ready     (pix.ready),
        .i_density       (pix.density),
        .i_pixel_radius  (pix.pixel_radius),
        .i_seed_valid    (seed.valid),
        .i_seed_ready    (seed.ready),
        .i_seed_x        (seed.seed_x),
        .i_seed_y        (seed.seed_y),
        .i_seed_radius   (seed.seed_radius),
        .o_fail_count    (fail_count),
        .o_pending       (pending_seeds),
        .o_seeds_checked (seeds_checked)
    );

    function automatic int clamp_dim(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Offers one pixel item after a random gap and returns at the edge where
    // it is accepted. Valid is left high so that a gapless next item follows
    // without a bubble.
    task automatic push_pixel(input logic [edsp_pkg::DENSITY_BITS-1:0] dens,
                              input logic [edsp_pkg::RADIUS_BITS-1:0] rad);
        int gap;
        int w;
        int h;
        bit last_col;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid        <= 1'b1;
        pix.density      <= dens;
        pix.pixel_radius <= rad;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        // Follow the position: a row that is not the last writes the line
        // buffer up to one behind its column, and up to its column at the
        // end of the row.
        w        = clamp_dim(int'(shadow_w), WIDTH_MIN, MAX_W);
        h        = clamp_dim(int'(shadow_h), int'(edsp_pkg::HEIGHT_MIN),
                             int'(edsp_pkg::HEIGHT_MAX));
        last_col = (pos_col >= w - 1);
        if (pos_row < h - 1 && pos_col > 0) begin
            if (last_col && pos_col + 1 > buf_extent) buf_extent = pos_col + 1;
            else if (pos_col > buf_extent) buf_extent = pos_col;
        end
        if (last_col) begin
            pos_col = 0;
            pos_row = (pos_row >= h - 1) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
        pixels_sent++;
    endtask

    // Stops offering pixels and waits until every predicted seed has come
    // out, then lets the pipeline settle.
    task automatic drain(input int tail);
        pix.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_seeds != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Writes the frame registers back to back, in the chosen order, while
    // the block is idle. On a row other than the first, a new width is held
    // to the part of the line buffer that has been written.
    task automatic set_frame(input bit wr_w, input bit wr_h, input bit h_first,
                             input logic [edsp_pkg::DIM_BITS-1:0] w_raw,
                             input logic [edsp_pkg::DIM_BITS-1:0] h_raw);
        logic [edsp_pkg::DIM_BITS-1:0] w_val;
        bit                            pick_h;
        w_val = w_raw;
        if (pos_row != 0 && clamp_dim(int'(w_raw), WIDTH_MIN, MAX_W) > buf_extent)
            w_val = edsp_pkg::DIM_BITS'(buf_extent);
        for (int k = 0; k < 2; k++) begin
            pick_h = (k == 0) ? h_first : !h_first;
            if (pick_h ? wr_h : wr_w) begin
                cfg_wr_en   <= 1'b1;
                cfg_addr    <= pick_h ? edsp_pkg::CFG_FRAME_HEIGHT : edsp_pkg::CFG_FRAME_WIDTH;
                cfg_wr_data <= pick_h ? h_raw : w_val;
                @(posedge i_clk);
                if (pick_h) shadow_h = h_raw;
                else shadow_w = w_val;
            end
        end
        cfg_wr_en <= 1'b0;
        frame_settings++;
    endtask

    // Seed sink: a random stall before each item, none in burst phases, and
    // once a long hold that lets the block back up into the pixel side.
    initial begin : seed_sink
        int stall;
        seed.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                seed.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0) begin
                    seed.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            seed.ready <= 1'b1;
            do @(posedge i_clk); while (seed.valid !== 1'b1);
        end
    end

    // Watchdog: ends the run when no item has moved on either channel for
    // too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix.valid && pix.ready) || (seed.valid && seed.ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int                                  n;
        int                                  phase;
        int                                  which;
        int                                  remaining;
        t_dens_mode                          mode;
        t_dens_mode                          m;
        bit                                  pressure;
        bit                                  h_first;
        logic [edsp_pkg::DIM_BITS-1:0]       w_raw;
        logic [edsp_pkg::DIM_BITS-1:0]       h_raw;
        logic [edsp_pkg::DENSITY_BITS-1:0]   dens;
        logic [edsp_pkg::RADIUS_BITS-1:0]    rad;

        pix.valid        = 1'b0;
        pix.density      = '0;
        pix.pixel_radius = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first under the reset frame size of 640 by 480: the
        // density extremes, exactly one half and just under it, and the
        // radius extremes, all on the first row.
        push_pixel(20'hFFFFF, 16'hFFFF);
        push_pixel(20'h00000, 16'h0000);
        push_pixel(20'h08000, 16'h1234);
        push_pixel(20'h07FFF, 16'hFFFF);
        push_pixel(20'hFFFFF, 16'hFFFF);
        push_pixel(20'h10000, 16'h8001);
        drain(SETTLE_CYCLES);

        // Shrink the width to 4 mid-row: the pixel at column 6 is taken as
        // the last column and wraps. A height of 0 is clamped to 2, so the
        // next row is the last one and emits nothing.
        set_frame(1'b1, 1'b1, 1'b0, 11'd4, 11'd0);
        push_pixel(20'hFFFFF, 16'h0001);
        repeat (4) push_pixel(20'hFFFFF, 16'hFFFF);
        push_pixel(20'h08000, 16'hA5A5);
        push_pixel(20'h07FFF, 16'h5A5A);
        push_pixel(20'hFFFFF, 16'hFFFF);
        push_pixel(20'h00000, 16'h0000);
        drain(SETTLE_CYCLES);

        // Width 0 clamps to the narrowest frame of 3 and height 2047 to 1024.
        // Full density on every pixel drives the accumulators toward their
        // upper saturation through the row carry.
        set_frame(1'b1, 1'b1, 1'b1, 11'd0, 11'd2047);
        for (int i = 0; i < 9; i++) push_pixel(20'hFFFFF, (i % 2) ? 16'h0000 : 16'hFFFF);

        // Random phases: a new frame setting each time, mostly small frames
        // so that many rows and frame wraps are seen, with the extremes and
        // the occasional very wide frame mixed in.
        phase = 0;
        while (pixels_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            drain(SETTLE_CYCLES);
            phase++;
            pressure = (phase == PRESSURE_PHASE);
            case ($urandom_range(0, 15))
                0:       w_raw = 11'd0;
                1:       w_raw = 11'd2047;
                2:       w_raw = 11'd1024;
                3:       w_raw = 11'd3;
                4:       w_raw = edsp_pkg::DIM_BITS'($urandom_range(13, 96));
                5:       w_raw = edsp_pkg::DIM_BITS'($urandom_range(0, 2047));
                default: w_raw = edsp_pkg::DIM_BITS'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 11))
                0:       h_raw = 11'd0;
                1:       h_raw = 11'd2047;
                2:       h_raw = 11'd2;
                3:       h_raw = edsp_pkg::DIM_BITS'($urandom_range(0, 2047));
                default: h_raw = edsp_pkg::DIM_BITS'($urandom_range(2, 6));
            endcase
            which   = $urandom_range(0, 3);
            h_first = $urandom_range(0, 1);
            if (pressure) begin
                w_raw = 11'd40;
                h_raw = 11'd8;
                which = 3;
            end
            set_frame(which != 1, which != 0, h_first, w_raw, h_raw);

            tx_no_gap   = pressure || ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            mode        = t_dens_mode'($urandom_range(0, 4));
            n           = $urandom_range(40, 200);
            remaining   = DIRECTED_ITEMS + RANDOM_ITEMS - pixels_sent;
            if (n > remaining) n = remaining;
            if (pressure) begin
                mode         = DENS_HALF;
                n            = 250;
                rx_no_stall  = 1'b0;
                rx_long_hold = 1'b1;
            end

            repeat (n) begin
                m = (mode == DENS_MIXED) ? t_dens_mode'($urandom_range(0, 3)) : mode;
                case (m)
                    DENS_HALF:   dens = edsp_pkg::DENSITY_BITS'($urandom_range(0, 20'h10000));
                    DENS_SPARSE: dens = edsp_pkg::DENSITY_BITS'($urandom_range(0, 20'h02000));
                    DENS_HEAVY:  dens = $urandom_range(0, 1) ? 20'hFFFFF :
                                        edsp_pkg::DENSITY_BITS'($urandom_range(20'hC0000,
                                                                               20'hFFFFF));
                    default:     dens = edsp_pkg::DENSITY_BITS'($urandom_range(0, 20'hFFFFF));
                endcase
                if ($urandom_range(0, 7) == 0) rad = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else rad = edsp_pkg::RADIUS_BITS'($urandom_range(0, 16'hFFFF));
                push_pixel(dens, rad);
            end
        end

        drain(END_CYCLES);
        $display("Run covered %0d pixel items under %0d frame settings, including one long",
                 pixels_sent, frame_settings);
        $display("seed-side hold; %0d seeds compared, %0d failures.", seeds_checked, fail_count);
        if (fail_count == 0 && pending_seeds == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/edsp_pkg.sv
src/edsp_pix_if.sv
src/edsp_seed_if.sv
src/edsp_ram.sv
src/error_diffusion_seed_picker.sv
verif/edsp_seed_checker.sv
verif/tb_error_diffusion_seed_picker.sv
